[rtl/cst_pkg.sv]
`default_nettype none

package cst_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_START = 2'd0;
    localparam logic [ACT_W-1:0] ACT_END   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] self_acc;
    } cst_frame_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        cst_frame_t       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } cst_ram_req_t;

endpackage

`default_nettype wire

[rtl/cst_if.sv]
`default_nettype none

interface cst_evt_if;
    import cst_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] timestamp;
    logic [ID_W-1:0]   function_id;

    modport source (output valid, action, timestamp, function_id, input ready);
    modport sink (input valid, action, timestamp, function_id, output ready);
endinterface

interface cst_res_if;
    import cst_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   closed_id;
    logic [TIME_W-1:0] total_ticks;
    logic [TIME_W-1:0] self_ticks;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, closed_id, total_ticks, self_ticks, status, last,
                    input ready);
    modport sink (input valid, closed_id, total_ticks, self_ticks, status, last,
                  output ready);
endinterface

`default_nettype wire

[rtl/call_stack_self_total_timer_top.sv]
// call stack self/total timer
// evt channel: one transfer per start, end or flush event (action, timestamp,
// function_id); action code 3 is taken and dropped with no effect.
// result channel: closed frames and error results, with last marking the
// final result of an event. the stack of open frames lives in one synchronous
// memory with a registered read, written through a single port. a start on
// an empty stack writes the new frame; on a nonempty one it reads the top,
// writes it back and writes the new frame. an end reads and returns the top;
// underflow gives an error result; overflow writes the top back, then gives
// the error; a flush returns one result per cycle after the first read while
// the result channel is not stalled. one event is in work at a time; evt.ready
// is high only between events, while a finished result may still sit in the
// output register. a stalled result channel holds the block before it loads
// the next result; nothing is dropped. reset empties the stack, zeroes the
// previous timestamp and clears the output valid; the memory is not cleared.
`default_nettype none

module call_stack_self_total_timer_top (
    input wire logic  clk,
    input wire logic  rst_n,
    cst_evt_if.sink   evt,
    cst_res_if.source result
);
    import cst_pkg::*;

    cst_ram_req_t ram_req;
    cst_frame_t   rd_data;

    cst_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .result  (result),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    cst_stack_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("stack read and write hit the same entry");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        evt.ready |-> !ram_req.we)
        else $error("stack written while waiting for an event");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != ST_OK)) |->
            (result.last && (result.closed_id == '0) && (result.total_ticks == '0)
             && (result.self_ticks == '0)))
        else $error("error result with nonzero fields");

endmodule

`default_nettype wire

[rtl/cst_stack_ram.sv]
`default_nettype none

module cst_stack_ram (
    input  wire logic                  clk,
    input  wire cst_pkg::cst_ram_req_t req,
    output cst_pkg::cst_frame_t        rd_data
);
    import cst_pkg::*;

    cst_frame_t mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/cst_ctrl.sv]
`default_nettype none

module cst_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    cst_evt_if.sink                    evt,
    cst_res_if.source                  result,
    output cst_pkg::cst_ram_req_t      ram_req,
    input  wire cst_pkg::cst_frame_t   rd_data
);
    import cst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_PUSH = 4'b0100,
        S_ERR  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [TIME_W-1:0] ts_reg, ts_next;
    logic [ID_W-1:0]   fid_reg, fid_next;
    logic [TIME_W-1:0] add_reg, add_next;
    logic [STAT_W-1:0] err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [TIME_W-1:0] out_total_reg;
    logic [TIME_W-1:0] out_self_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_last_reg;

    logic              fire;
    logic              slot_free;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [TIME_W-1:0] new_self;
    logic              emit;
    logic [ID_W-1:0]   e_id;
    logic [TIME_W-1:0] e_total;
    logic [TIME_W-1:0] e_self;
    logic [STAT_W-1:0] e_status;
    logic              e_last;

    assign evt.ready = (state_reg == S_IDLE);
    assign fire      = evt.valid && evt.ready && (evt.action != ACT_NONE);
    assign slot_free = !out_valid_reg || result.ready;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign new_self  = rd_data.self_acc + add_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        act_next   = act_reg;
        ts_next    = ts_reg;
        fid_next   = fid_reg;
        add_next   = add_reg;
        err_next   = err_reg;
        ram_req    = '0;
        emit       = 1'b0;
        e_id       = '0;
        e_total    = '0;
        e_self     = '0;
        e_status   = ST_OK;
        e_last     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (fire)
                begin
                    prev_next = evt.timestamp;
                    act_next  = evt.action;
                    ts_next   = evt.timestamp;
                    fid_next  = evt.function_id;
                    add_next  = evt.timestamp - prev_reg;
                    if (count_reg != '0)
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = cnt_m1[IDX_W-1:0];
                        state_next    = S_LOOK;
                    end
                    else
                    begin
                        case (evt.action)
                            ACT_START: state_next = S_PUSH;
                            ACT_END:
                            begin
                                err_next   = ST_UNDERFLOW;
                                state_next = S_ERR;
                            end
                            default: state_next = S_IDLE;
                        endcase
                    end
                end
            end
            S_LOOK:
            begin
                case (act_reg)
                    ACT_START:
                    begin
                        ram_req.we               = 1'b1;
                        ram_req.waddr            = cnt_m1[IDX_W-1:0];
                        ram_req.wdata.id         = rd_data.id;
                        ram_req.wdata.start_time = rd_data.start_time;
                        ram_req.wdata.self_acc   = new_self;
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            err_next   = ST_OVERFLOW;
                            state_next = S_ERR;
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                    default:
                    begin
                        if (slot_free)
                        begin
                            emit       = 1'b1;
                            e_id       = rd_data.id;
                            e_total    = ts_reg - rd_data.start_time;
                            e_self     = new_self;
                            e_last     = (act_reg == ACT_END) || (count_reg == CNT_W'(1));
                            count_next = cnt_m1;
                            add_next   = '0;
                            if ((act_reg == ACT_FLUSH) && (count_reg != CNT_W'(1)))
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = cnt_m2[IDX_W-1:0];
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                    end
                endcase
            end
            S_PUSH:
            begin
                ram_req.we               = 1'b1;
                ram_req.waddr            = count_reg[IDX_W-1:0];
                ram_req.wdata.id         = fid_reg;
                ram_req.wdata.start_time = ts_reg;
                ram_req.wdata.self_acc   = '0;
                count_next               = count_reg + CNT_W'(1);
                state_next               = S_IDLE;
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_status   = err_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        ts_reg  <= ts_next;
        fid_reg <= fid_next;
        add_reg <= add_next;
        err_reg <= err_next;
        if (emit)
        begin
            out_id_reg     <= e_id;
            out_total_reg  <= e_total;
            out_self_reg   <= e_self;
            out_status_reg <= e_status;
            out_last_reg   <= e_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.closed_id   = out_id_reg;
    assign result.total_ticks = out_total_reg;
    assign result.self_ticks  = out_self_reg;
    assign result.status      = out_status_reg;
    assign result.last        = out_last_reg;

endmodule

`default_nettype wire
